>>> rtl/p2ba_pkg.sv
// Package for the power-of-two bucket allocator.
// Field widths, heap constants, command and register codes, sequencer states.
// No dependencies.
package p2ba_pkg;

  localparam int SIZE_W     = 16;
  localparam int PTR_W      = 16;
  localparam int START_W    = 16;
  localparam int LIMIT_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int RAW_BKT_W  = 5;
  localparam int CARVE_W    = 9;

  localparam logic [START_W-1:0] HEAP_START_RST = 16'd1024;
  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 17'd65536;

  localparam logic [7:0] MAGIC_BYTE       = 8'hff;
  localparam logic [9:0] PAGE_MASK        = 10'h3ff;
  localparam int         PAGE_SIZE        = 1024;
  localparam int         CHUNK_LOG        = 11;
  localparam int         SMALL_BUCKET_MAX = 8;
  localparam int         MIN_LOG          = 3;
  localparam int         HEADER_BYTES     = 4;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_START = 2'd0,
    CFG_HEAP_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_HEAD,
    ST_R_ALIGN,
    ST_R_FIT,
    ST_R_CARVE,
    ST_A_ISSUE,
    ST_A_LINK,
    ST_F_HDR,
    ST_F_HEAD,
    ST_RESP
  } state_t;

endpackage

>>> rtl/p2ba_if.sv
// Handshake channels of the bucket allocator: request, response, config write.
// Depends on p2ba_pkg for field widths.
interface p2ba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [p2ba_pkg::SIZE_W-1:0]  request_size;
  logic [p2ba_pkg::PTR_W-1:0]   block_pointer;
  modport source (output valid, command, request_size, block_pointer, input ready);
  modport sink   (input valid, command, request_size, block_pointer, output ready);
endinterface

interface p2ba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [p2ba_pkg::PTR_W-1:0]  granted_pointer;
  logic                        failed;
  modport source (output valid, granted_pointer, failed, input ready);
  modport sink   (input valid, granted_pointer, failed, output ready);
endinterface

interface p2ba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [p2ba_pkg::CFG_IDX_W-1:0]   index;
  logic [p2ba_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/power_of_two_bucket_allocator.sv
// Power-of-two bucket allocator: free-list heads and header words in two
// synchronous memories, driven by a read-modify-write sequencer.
// Depends on p2ba_pkg and the channel interfaces in p2ba_if.sv.
//
//   channel  dir  fields                                    handshake
//   req      in   command, request_size, block_pointer      valid/ready
//   rsp      out  granted_pointer, failed                   valid/ready
//   cfg      in   index, data                               valid/ready
//
// A refill carves N = 2^(8-b) blocks for b <= 8, else 1, one header write per
// cycle on the single write port. After reset a clearing pass zeroes both
// memories; req.ready stays low, cfg writes are taken.
// A stalled response holds in the output register; the next request is
// taken meanwhile and waits in the response state.
module power_of_two_bucket_allocator #(
  parameter int NUM_BUCKETS = 14,
  parameter int ADDR_BITS   = 16
) (
  input logic        clk,
  input logic        rst,
  p2ba_req_if.sink   req,
  p2ba_rsp_if.source rsp,
  p2ba_cfg_if.sink   cfg
);

  localparam int HW        = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam int HDR_AW    = ADDR_BITS - 2;
  localparam int HDR_DEPTH = 1 << HDR_AW;
  localparam int BKT_W     = $clog2(NUM_BUCKETS);
  localparam int BRK_W     = ADDR_BITS + 1;
  localparam int LIMW      = (BRK_W > p2ba_pkg::LIMIT_W) ? BRK_W : p2ba_pkg::LIMIT_W;
  localparam int SUMW      = ((BRK_W > NUM_BUCKETS + p2ba_pkg::MIN_LOG) ?
                              BRK_W : NUM_BUCKETS + p2ba_pkg::MIN_LOG) + 1;

  function automatic logic [p2ba_pkg::RAW_BKT_W-1:0] raw_bucket(
    input logic [p2ba_pkg::SIZE_W-1:0] size
  );
    logic [p2ba_pkg::SIZE_W:0]   sum;
    logic [p2ba_pkg::SIZE_W-2:0] words;
    logic [p2ba_pkg::RAW_BKT_W-1:0] b;
    sum   = {1'b0, size} + (p2ba_pkg::SIZE_W + 1)'(3);
    words = sum[p2ba_pkg::SIZE_W:2];
    b     = '0;
    for (int i = 1; i < p2ba_pkg::SIZE_W - 1; i++) begin
      if (words[i]) b = p2ba_pkg::RAW_BKT_W'(i);
    end
    return b;
  endfunction

  p2ba_pkg::state_t state, state_next;

  logic [p2ba_pkg::LIMIT_W-1:0] heap_limit;
  logic [BRK_W-1:0]             break_addr;
  logic [HDR_AW-1:0]            clr_idx;
  logic [BKT_W-1:0]             bkt;
  logic                         bkt_bad;
  logic [ADDR_BITS-1:0]         cur_ptr;
  logic [ADDR_BITS-1:0]         op_ptr;
  logic [BRK_W-1:0]             brk_al;
  logic [ADDR_BITS-1:0]         carve_addr;
  logic [p2ba_pkg::CARVE_W-1:0] carve_left;
  logic [p2ba_pkg::PTR_W-1:0]   res_ptr;
  logic                         res_fail;
  logic                         rsp_valid;
  logic [p2ba_pkg::PTR_W-1:0]   out_ptr;
  logic                         out_fail;

  logic [HW-1:0]        hdr_mem [HDR_DEPTH];
  logic                 hdr_we;
  logic [HDR_AW-1:0]    hdr_waddr, hdr_raddr;
  logic [HW-1:0]        hdr_wdata, hdr_rdata;

  logic [ADDR_BITS-1:0] heads_mem [NUM_BUCKETS];
  logic                 heads_we;
  logic [BKT_W-1:0]     heads_waddr, heads_raddr;
  logic [ADDR_BITS-1:0] heads_wdata, heads_rdata;

  logic [p2ba_pkg::RAW_BKT_W-1:0] raw_b;
  logic                 raw_bad;
  logic [ADDR_BITS-1:0] bp_in, op_in;
  logic [LIMW-1:0]      lim_ext, span_ext;
  logic [BRK_W-1:0]     lim_eff, brk_up, brk_algn;
  logic [BKT_W:0]       blog;
  logic                 small_bkt;
  logic [SUMW-1:0]      bsize, chunk, fit_sum;
  logic [p2ba_pkg::CARVE_W-1:0] carve_count;
  logic [ADDR_BITS-1:0] carve_next;
  logic                 free_ok;
  logic                 slot_free;

  assign raw_b   = raw_bucket(req.request_size);
  assign raw_bad = 32'(raw_b) >= NUM_BUCKETS;
  assign bp_in   = ADDR_BITS'(req.block_pointer);
  assign op_in   = bp_in - ADDR_BITS'(p2ba_pkg::HEADER_BYTES);

  assign lim_ext  = LIMW'(heap_limit);
  assign span_ext = LIMW'(1) << ADDR_BITS;
  assign lim_eff  = (lim_ext > span_ext) ? BRK_W'(span_ext) : BRK_W'(lim_ext);

  assign brk_up   = (|break_addr[9:0]) ?
                    (break_addr | BRK_W'(p2ba_pkg::PAGE_MASK)) + BRK_W'(1) : break_addr;
  assign brk_algn = (brk_up == '0) ? BRK_W'(p2ba_pkg::PAGE_SIZE) : brk_up;

  assign blog        = {1'b0, bkt} + (BKT_W + 1)'(p2ba_pkg::MIN_LOG);
  assign small_bkt   = 32'(bkt) <= p2ba_pkg::SMALL_BUCKET_MAX;
  assign bsize       = SUMW'(1) << blog;
  assign chunk       = small_bkt ? (SUMW'(1) << p2ba_pkg::CHUNK_LOG) : bsize;
  assign carve_count = small_bkt ?
                       (p2ba_pkg::CARVE_W'(1) << (p2ba_pkg::SMALL_BUCKET_MAX - 32'(bkt))) :
                       p2ba_pkg::CARVE_W'(1);
  assign fit_sum     = SUMW'(brk_al) + chunk;
  assign carve_next  = ADDR_BITS'(SUMW'(carve_addr) + bsize);

  assign free_ok   = (hdr_rdata[7:0] == p2ba_pkg::MAGIC_BYTE) &&
                     (32'(hdr_rdata[15:8]) < NUM_BUCKETS);
  assign slot_free = !rsp_valid || rsp.ready;

  assign req.ready           = (state == p2ba_pkg::ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = rsp_valid;
  assign rsp.granted_pointer = out_ptr;
  assign rsp.failed          = out_fail;

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
    hdr_rdata <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[heads_waddr] <= heads_wdata;
    heads_rdata <= heads_mem[heads_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      p2ba_pkg::ST_CLEAR:   if (&clr_idx) state_next = p2ba_pkg::ST_IDLE;
      p2ba_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.command == p2ba_pkg::CMD_FREE) begin
            state_next = (bp_in == '0) ? p2ba_pkg::ST_RESP : p2ba_pkg::ST_F_HDR;
          end else begin
            state_next = p2ba_pkg::ST_A_HEAD;
          end
        end
      end
      p2ba_pkg::ST_A_HEAD: begin
        priority if (bkt_bad) state_next = p2ba_pkg::ST_RESP;
        else if (heads_rdata == '0) state_next = p2ba_pkg::ST_R_ALIGN;
        else state_next = p2ba_pkg::ST_A_LINK;
      end
      p2ba_pkg::ST_R_ALIGN:
        state_next = (brk_algn > lim_eff) ? p2ba_pkg::ST_RESP : p2ba_pkg::ST_R_FIT;
      p2ba_pkg::ST_R_FIT:
        state_next = (fit_sum > SUMW'(lim_eff)) ? p2ba_pkg::ST_RESP : p2ba_pkg::ST_R_CARVE;
      p2ba_pkg::ST_R_CARVE:
        if (carve_left == p2ba_pkg::CARVE_W'(1)) state_next = p2ba_pkg::ST_A_ISSUE;
      p2ba_pkg::ST_A_ISSUE: state_next = p2ba_pkg::ST_A_LINK;
      p2ba_pkg::ST_A_LINK:  state_next = p2ba_pkg::ST_RESP;
      p2ba_pkg::ST_F_HDR:
        state_next = free_ok ? p2ba_pkg::ST_F_HEAD : p2ba_pkg::ST_RESP;
      p2ba_pkg::ST_F_HEAD:  state_next = p2ba_pkg::ST_RESP;
      p2ba_pkg::ST_RESP:    if (slot_free) state_next = p2ba_pkg::ST_IDLE;
      default:              state_next = p2ba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    hdr_we      = 1'b0;
    hdr_waddr   = '0;
    hdr_wdata   = '0;
    hdr_raddr   = '0;
    heads_we    = 1'b0;
    heads_waddr = '0;
    heads_wdata = '0;
    heads_raddr = '0;
    unique case (state)
      p2ba_pkg::ST_CLEAR: begin
        hdr_we      = 1'b1;
        hdr_waddr   = clr_idx;
        heads_we    = clr_idx < HDR_AW'(NUM_BUCKETS);
        heads_waddr = BKT_W'(clr_idx);
      end
      p2ba_pkg::ST_IDLE: begin
        hdr_raddr   = op_in[ADDR_BITS-1:2];
        heads_raddr = BKT_W'(raw_b);
      end
      p2ba_pkg::ST_A_HEAD: hdr_raddr = heads_rdata[ADDR_BITS-1:2];
      p2ba_pkg::ST_R_CARVE: begin
        hdr_we    = 1'b1;
        hdr_waddr = carve_addr[ADDR_BITS-1:2];
        hdr_wdata = (carve_left == p2ba_pkg::CARVE_W'(1)) ? '0 : HW'(carve_next);
      end
      p2ba_pkg::ST_A_ISSUE: hdr_raddr = cur_ptr[ADDR_BITS-1:2];
      p2ba_pkg::ST_A_LINK: begin
        heads_we    = 1'b1;
        heads_waddr = bkt;
        heads_wdata = hdr_rdata[ADDR_BITS-1:0];
        hdr_we      = 1'b1;
        hdr_waddr   = cur_ptr[ADDR_BITS-1:2];
        hdr_wdata   = HW'({8'(bkt), p2ba_pkg::MAGIC_BYTE});
      end
      p2ba_pkg::ST_F_HDR: heads_raddr = hdr_rdata[8 +: BKT_W];
      p2ba_pkg::ST_F_HEAD: begin
        hdr_we      = 1'b1;
        hdr_waddr   = op_ptr[ADDR_BITS-1:2];
        hdr_wdata   = HW'(heads_rdata);
        heads_we    = 1'b1;
        heads_waddr = bkt;
        heads_wdata = op_ptr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= p2ba_pkg::ST_CLEAR;
      clr_idx    <= '0;
      heap_limit <= p2ba_pkg::HEAP_LIMIT_RST;
      break_addr <= BRK_W'(ADDR_BITS'(p2ba_pkg::HEAP_START_RST));
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        p2ba_pkg::ST_CLEAR: clr_idx <= clr_idx + HDR_AW'(1);
        p2ba_pkg::ST_IDLE: begin
          if (req.valid) begin
            res_ptr  <= '0;
            res_fail <= 1'b0;
            bkt      <= BKT_W'(raw_b);
            bkt_bad  <= raw_bad;
            op_ptr   <= op_in;
          end
        end
        p2ba_pkg::ST_A_HEAD: begin
          if (bkt_bad) res_fail <= 1'b1;
          cur_ptr <= heads_rdata;
        end
        p2ba_pkg::ST_R_ALIGN: begin
          if (brk_algn > lim_eff) begin
            res_fail <= 1'b1;
          end else begin
            break_addr <= brk_algn;
            brk_al     <= brk_algn;
          end
        end
        p2ba_pkg::ST_R_FIT: begin
          if (fit_sum > SUMW'(lim_eff)) begin
            res_fail <= 1'b1;
          end else begin
            break_addr <= BRK_W'(fit_sum);
            carve_addr <= brk_al[ADDR_BITS-1:0];
            carve_left <= carve_count;
          end
        end
        p2ba_pkg::ST_R_CARVE: begin
          carve_addr <= carve_next;
          carve_left <= carve_left - p2ba_pkg::CARVE_W'(1);
          cur_ptr    <= brk_al[ADDR_BITS-1:0];
        end
        p2ba_pkg::ST_A_LINK:
          res_ptr <= p2ba_pkg::PTR_W'(cur_ptr + ADDR_BITS'(p2ba_pkg::HEADER_BYTES));
        p2ba_pkg::ST_F_HDR: bkt <= hdr_rdata[8 +: BKT_W];
        default: ;
      endcase

      if (state == p2ba_pkg::ST_RESP && slot_free) begin
        rsp_valid <= 1'b1;
        out_ptr   <= res_ptr;
        out_fail  <= res_fail;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg.valid) begin
        if (cfg.index == p2ba_pkg::CFG_HEAP_START) begin
          break_addr <= BRK_W'(ADDR_BITS'(cfg.data[p2ba_pkg::START_W-1:0]));
        end else if (cfg.index == p2ba_pkg::CFG_HEAP_LIMIT) begin
          heap_limit <= cfg.data;
        end
      end
    end
  end

endmodule

>>> test/power_of_two_bucket_allocator_checker.sv
// Checker for the power-of-two bucket allocator: watches the request, response
// and config channels, keeps its own heap model and compares every grant.
// Depends on p2ba_pkg and the channel interfaces in p2ba_if.sv.
module power_of_two_bucket_allocator_checker
  import p2ba_pkg::*;
#(
  parameter int NUM_BUCKETS = 14,
  parameter int ADDR_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  p2ba_req_if  req,
  p2ba_rsp_if  rsp,
  p2ba_cfg_if  cfg,
  input  logic end_of_test,
  output int   errors
);

  localparam int HDR_DEPTH = 1 << (ADDR_BITS - 2);
  localparam int ADDR_SPAN = 1 << ADDR_BITS;

  typedef struct packed {
    logic [PTR_W-1:0] granted_pointer;
    logic             failed;
  } grant_t;

  logic [PTR_W-1:0]   list_head [NUM_BUCKETS];
  logic [PTR_W-1:0]   hdr_word  [HDR_DEPTH];
  logic [LIMIT_W-1:0] brk;
  logic [START_W-1:0] heap_start;
  logic [LIMIT_W-1:0] heap_limit;
  grant_t             pending_grants [$];
  bit                 end_seen;

  initial errors = 0;

  task automatic report(string what, int want, int got);
    $display("MISMATCH %s: expected %0h got %0h", what, want, got);
    errors++;
  endtask

  function automatic int bucket_for(logic [SIZE_W-1:0] req_size);
    int n, sr, b;
    n  = int'(req_size) + HEADER_BYTES;
    n  = (n + 3) & ~3;
    sr = (n - 1) >> 2;
    b  = 0;
    sr = sr >> 1;
    while (sr != 0) begin
      b++;
      sr = sr >> 1;
    end
    return b;
  endfunction

  // carve a fresh chunk off the break into a null-terminated chain
  function automatic void refill_bucket(int b);
    int lim, base, blog, clog, bsize, count, addr, next_addr;
    lim = (int'(heap_limit) > ADDR_SPAN) ? ADDR_SPAN : int'(heap_limit);
    base = int'(brk);
    if ((base & int'(PAGE_MASK)) != 0)
      base += PAGE_SIZE - (base & int'(PAGE_MASK));
    if (base == 0)
      base = PAGE_SIZE;
    if (base > lim)
      return;
    brk  = LIMIT_W'(base);
    blog = b + MIN_LOG;
    clog = (b <= SMALL_BUCKET_MAX) ? CHUNK_LOG : blog;
    if ((1 << clog) > lim - base)
      return;
    brk   = LIMIT_W'(base + (1 << clog));
    bsize = 1 << blog;
    count = 1 << (clog - blog);
    for (int i = 0; i < count; i++) begin
      addr      = base + i * bsize;
      next_addr = (i + 1 < count) ? addr + bsize : 0;
      hdr_word[(addr % ADDR_SPAN) >> 2] = PTR_W'(next_addr);
    end
    list_head[b] = PTR_W'(base);
  endfunction

  function automatic grant_t predict_grant(cmd_t command, logic [SIZE_W-1:0] req_size,
                                           logic [PTR_W-1:0] ptr);
    grant_t           g;
    int               b, fb;
    logic [PTR_W-1:0] p, op, hw;
    g = '0;
    if (command == CMD_ALLOC) begin
      b = bucket_for(req_size);
      if (b >= NUM_BUCKETS) begin
        g.failed = 1'b1;
        return g;
      end
      if (list_head[b] == '0)
        refill_bucket(b);
      p = list_head[b];
      if (p == '0) begin
        g.failed = 1'b1;
        return g;
      end
      list_head[b]           = hdr_word[p[PTR_W-1:2]];
      hdr_word[p[PTR_W-1:2]] = {8'(b), MAGIC_BYTE};
      g.granted_pointer      = p + PTR_W'(HEADER_BYTES);
    end else if (ptr != '0) begin
      op = ptr - PTR_W'(HEADER_BYTES);
      hw = hdr_word[op[PTR_W-1:2]];
      fb = int'(hw[15:8]);
      if (hw[7:0] == MAGIC_BYTE && fb < NUM_BUCKETS) begin
        hdr_word[op[PTR_W-1:2]] = list_head[fb];
        list_head[fb]           = op;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (rst) begin
      foreach (list_head[i]) list_head[i] = '0;
      foreach (hdr_word[i]) hdr_word[i] = '0;
      heap_start = HEAP_START_RST;
      heap_limit = HEAP_LIMIT_RST;
      brk        = LIMIT_W'(HEAP_START_RST);
      pending_grants.delete();
      end_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_HEAP_START: begin
            heap_start = cfg.data[START_W-1:0];
            brk        = LIMIT_W'(heap_start);
          end
          CFG_HEAP_LIMIT: heap_limit = cfg.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        pending_grants.push_back(predict_grant(cmd_t'(req.command), req.request_size,
                                               req.block_pointer));
      if (rsp.valid && rsp.ready) begin
        if (pending_grants.size() == 0) begin
          report("unexpected response", 0, int'(rsp.granted_pointer));
        end else begin
          exp_g = pending_grants.pop_front();
          if (rsp.granted_pointer !== exp_g.granted_pointer)
            report("granted_pointer", int'(exp_g.granted_pointer), int'(rsp.granted_pointer));
          if (rsp.failed !== exp_g.failed)
            report("failed", int'(exp_g.failed), int'(rsp.failed));
        end
      end
      if (end_of_test && !end_seen) begin
        end_seen = 1;
        if (pending_grants.size() != 0)
          report("responses never returned", 0, pending_grants.size());
      end
    end
  end

endmodule

>>> test/power_of_two_bucket_allocator_test.sv
// Top of the bucket allocator test: clock, reset, request and config stimulus,
// receiver stalls, watchdog and verdict; checking lives in the checker module.
// Depends on p2ba_pkg, p2ba_if.sv, the block and the checker.
module power_of_two_bucket_allocator_test;
  import p2ba_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk;
  logic rst;
  logic end_of_test;
  int   errors;
  int   req_cnt;
  int   rsp_cnt;
  int   idle_cycles;
  int   burst_left;

  logic [PTR_W-1:0] live_ptrs [$];
  logic [PTR_W-1:0] new_grant;
  logic             grant_seen;

  p2ba_req_if req_ch ();
  p2ba_rsp_if rsp_ch ();
  p2ba_cfg_if cfg_ch ();

  power_of_two_bucket_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  power_of_two_bucket_allocator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .end_of_test (end_of_test),
    .errors      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off once traffic is flowing
  initial begin
    int mode, seg;
    bit held;
    held = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      repeat (seg) begin
        @(posedge clk);
        if (!held && rsp_cnt >= 250) begin
          held = 1;
          rsp_ch.ready <= 1'b0;
          repeat (400) @(posedge clk);
        end
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ~rsp_ch.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_cnt     <= 0;
      rsp_cnt     <= 0;
      idle_cycles <= 0;
      grant_seen  <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        req_cnt <= req_cnt + 1;
      if (rsp_ch.valid && rsp_ch.ready)
        rsp_cnt <= rsp_cnt + 1;
      grant_seen <= rsp_ch.valid && rsp_ch.ready && !rsp_ch.failed &&
                    rsp_ch.granted_pointer != '0;
      new_grant  <= rsp_ch.granted_pointer;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // granted blocks become candidates for well-formed frees
  always @(negedge clk) begin
    if (grant_seen) begin
      live_ptrs.push_back(new_grant);
      if (live_ptrs.size() > 128)
        void'(live_ptrs.pop_front());
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_heap(logic [START_W-1:0] start, logic [LIMIT_W-1:0] limit,
                          bit write_start);
    if (write_start)
      write_reg(CFG_HEAP_START, CFG_DATA_W'(start));
    write_reg(CFG_HEAP_LIMIT, CFG_DATA_W'(limit));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_req(cmd_t c, logic [SIZE_W-1:0] sz, logic [PTR_W-1:0] ptr);
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= c;
    req_ch.request_size  <= sz;
    req_ch.block_pointer <= ptr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (rsp_cnt != req_cnt) @(posedge clk);
  endtask

  task automatic random_item();
    int               r, pick, k;
    logic [SIZE_W-1:0] sz;
    logic [PTR_W-1:0]  ptr;
    r = $urandom_range(0, 99);
    if (r < ((live_ptrs.size() > 48) ? 35 : 60)) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        k  = $urandom_range(0, 6);
        sz = SIZE_W'($urandom_range(0, (8 << k) - HEADER_BYTES));
      end else if (pick < 95) begin
        k  = $urandom_range(7, 11);
        sz = SIZE_W'($urandom_range(0, (8 << k) - HEADER_BYTES));
      end else begin
        sz = SIZE_W'($urandom);
      end
      send_req(CMD_ALLOC, sz, PTR_W'($urandom));
    end else if (r < 90 && live_ptrs.size() != 0) begin
      pick = $urandom_range(0, live_ptrs.size() - 1);
      ptr  = live_ptrs[pick];
      if ($urandom_range(0, 9) != 0)
        live_ptrs.delete(pick);
      send_req(CMD_FREE, SIZE_W'($urandom), ptr);
    end else begin
      case ($urandom_range(0, 3))
        0: ptr = '0;
        1: ptr = PTR_W'($urandom);
        2: ptr = ((live_ptrs.size() != 0) ? live_ptrs[0] : PTR_W'($urandom)) +
                 PTR_W'($urandom_range(1, 7));
        default: ptr = {13'($urandom), 3'b100};
      endcase
      send_req(CMD_FREE, SIZE_W'($urandom), ptr);
    end
  endtask

  initial begin
    int rnd_start;
    int rnd_limit;
    rst                  <= 1'b1;
    end_of_test          <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.command       <= CMD_ALLOC;
    req_ch.request_size  <= '0;
    req_ch.block_pointer <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_HEAP_START;
    cfg_ch.data          <= '0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // unused register slots, then a break of zero
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, 17'h1ffff);
    set_heap(16'd0, HEAP_LIMIT_RST, 1);
    send_req(CMD_ALLOC, 16'd0, 16'd0);
    send_req(CMD_ALLOC, 16'hffff, 16'hffff);
    send_req(CMD_ALLOC, 16'd65532, 16'd0);
    send_req(CMD_ALLOC, 16'd4, 16'd0);
    send_req(CMD_ALLOC, 16'd4000, 16'd0);
    send_req(CMD_ALLOC, 16'd32000, 16'd0);
    send_req(CMD_ALLOC, 16'd32000, 16'd0);
    send_req(CMD_FREE, 16'hffff, 16'd1028);
    send_req(CMD_FREE, 16'd0, 16'd1028);
    send_req(CMD_FREE, 16'd0, 16'd0);
    send_req(CMD_FREE, 16'd0, 16'd1);
    send_req(CMD_FREE, 16'd0, 16'd1037);
    send_req(CMD_ALLOC, 16'd0, 16'd0);
    send_req(CMD_ALLOC, 16'd0, 16'd0);
    send_req(CMD_ALLOC, 16'd0, 16'd0);
    send_req(CMD_FREE, 16'd0, 16'hffff);
    send_req(CMD_ALLOC, 16'd600, 16'd0);
    send_req(CMD_FREE, 16'd0, 16'd39940);
    send_req(CMD_ALLOC, 16'd1020, 16'd0);
    drain();

    // limit below the aligned break
    set_heap(16'd8, 17'd8, 1);
    send_req(CMD_ALLOC, 16'd100, 16'd0);
    send_req(CMD_ALLOC, 16'd0, 16'd0);
    send_req(CMD_FREE, 16'd0, 16'd1028);
    drain();

    // break at the top of the heap
    set_heap(16'd65528, 17'd65536, 1);
    send_req(CMD_ALLOC, 16'd10, 16'd0);
    send_req(CMD_ALLOC, 16'd2000, 16'd0);
    send_req(CMD_ALLOC, 16'd3000, 16'd0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_heap(HEAP_START_RST, HEAP_LIMIT_RST, 1);
        1: set_heap(16'd0, 17'd65536, 1);
        2: set_heap(16'd8, 17'd20000, 1);
        3: set_heap(16'd0, 17'd40000, 0);
        4: set_heap(16'd30000, 17'd65536, 1);
        5: set_heap(16'd1024, 17'd8192, 1);
        default: begin
          rnd_start = $urandom_range(8, 65528);
          rnd_limit = $urandom_range(rnd_start, 65536);
          set_heap(START_W'(rnd_start), LIMIT_W'(rnd_limit), 1);
        end
      endcase
      repeat (100) random_item();
      drain();
    end

    repeat (30) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
